>>> hw/rtl/bfra_pkg.sv
// Shared types and constants for the best-fit range allocator.
// Depends on nothing; imported by the allocator core.
`timescale 1ns / 1ps
package bfra_pkg;

  localparam int unsigned MAX_SLOTS       = 1024;
  localparam int unsigned MAX_FREE_RANGES = 512;
  localparam int unsigned DEFER_DEPTH     = 64;

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_FREE_RANGES);
  localparam int unsigned DQ_W   = $clog2(DEFER_DEPTH);
  localparam int unsigned FILL_W = $clog2(DEFER_DEPTH + 1);
  localparam int unsigned ADR_W  = 48;
  localparam int unsigned INC_W  = 9;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned REL_W  = 7;
  localparam int unsigned BIT_W  = $clog2(ADR_W);
  localparam int unsigned PADDR_W = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FIT     = 2'd1,
    STAT_QUEUE_FULL = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    REG_HEAP_SIZE = 2'd0,
    REG_BASE_ADDR = 2'd1,
    REG_HANDLE_INC = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_SCAN, S_A_PICK, S_A_MUL, S_A_WR, S_F_DIV, S_F_WR,
    S_R_HEAD, S_R_CHK, S_R_SCAN, S_R_WR1, S_R_WR2, S_DONE
  } state_e;

  typedef struct packed {
    logic [SLOT_W-1:0] off;
    logic [SLOT_W-1:0] len;
  } range_t;

  typedef struct packed {
    logic [ADR_W-1:0]  frame;
    logic [SLOT_W-1:0] off;
    logic [SLOT_W-1:0] cnt;
  } defer_t;

endpackage

>>> hw/rtl/best_fit_range_allocator_core.sv
// Best-fit free-range allocator core: free-range table, deferred free queue, sequencer.
// Depends on bfra_pkg and bfra_ram.
`timescale 1ns / 1ps
// The block tracks a heap of descriptor slots as a table of free ranges held in a
// 512-entry RAM; an entry with zero length is an unused row. One command is taken at a
// time and answered by one result beat (a heap_size write aborts it). Allocate scans
// the whole table through the single read port to find the smallest fitting range,
// lowest offset on a tie. Free divides (handle - base) by the increment one quotient
// bit per cycle and queues the range with its frame in a 64-entry queue. Release pops
// queued ranges from the head while their frame is at most the given limit; each
// popped range that passes the range check costs one full table scan to find overlap,
// neighbours and a spare row. The table scan sets the rate. After reset, and after
// every write of heap_size, a clearing pass over all 512 rows rebuilds the table while
// the input is not ready; configuration writes are still taken. A finished result
// waits in the output register while the next command may already be accepted.
module best_fit_range_allocator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfra_pkg::PADDR_W-1:0]        paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready,
  // commands
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [bfra_pkg::SLOT_W-1:0]         count_i,
  input  logic [bfra_pkg::ADR_W-1:0]          handle_i,
  input  logic [bfra_pkg::ADR_W-1:0]          frame_number_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [bfra_pkg::ADR_W-1:0]          out_handle_o,
  output logic [bfra_pkg::OFF_W-1:0]          out_offset_o,
  output logic [bfra_pkg::SLOT_W-1:0]         granted_o,
  output logic [bfra_pkg::SLOT_W-1:0]         free_slots_o,
  output logic [bfra_pkg::REL_W-1:0]          released_o
);
  import bfra_pkg::*;

  localparam logic [IDX_W:0]  SCAN_END = (IDX_W+1)'(MAX_FREE_RANGES);
  localparam logic [IDX_W:0]  CLR_END  = (IDX_W+1)'(MAX_FREE_RANGES - 1);
  localparam logic [SLOT_W-1:0] SLOTS_MAX = SLOT_W'(MAX_SLOTS);

  state_e state_q, state_d;

  // configuration registers
  logic [SLOT_W-1:0] heap_q;
  logic [ADR_W-1:0]  base_q;
  logic [INC_W-1:0]  inc_q;
  logic [INC_W-1:0]  inc_eff;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic              heap_wr;
  logic [SLOT_W-1:0] heap_new;

  // latched command
  logic [1:0]        cmd_q;
  logic [SLOT_W-1:0] cnt_q;
  logic [ADR_W-1:0]  frame_q;
  logic              in_acc;

  // scan sequencer
  logic [IDX_W:0]    scan_q;
  logic              prc_q;
  logic [IDX_W-1:0]  idx_q;
  logic              scan_end;

  // allocate
  logic              found_q;
  range_t            best_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [SLOT_W+INC_W-1:0] prod_q;

  // free divider
  logic [ADR_W-1:0]  div_q;
  logic [INC_W-1:0]  rem_q;
  logic [BIT_W-1:0]  bit_q;
  logic [INC_W:0]    rem_t;
  logic              q_bit;

  // release
  logic [SLOT_W-1:0] rel_off_q, rel_cnt_q;
  logic              rel_bad_q, prev_q, next_q, hole_q;
  range_t            prev_r_q;
  logic [IDX_W-1:0]  prev_idx_q, next_idx_q, hole_idx_q;
  logic [SLOT_W-1:0] next_len_q;
  logic              pre_bad;
  logic              pop_ok;

  // queue
  logic [DQ_W-1:0]   head_q, tail_q;
  logic [FILL_W-1:0] fill_q;
  logic [SLOT_W-1:0] free_q;

  // result under construction and output register
  logic [1:0]        r_stat_q;
  logic [ADR_W-1:0]  r_hdl_q;
  logic [OFF_W-1:0]  r_off_q;
  logic [SLOT_W-1:0] r_grant_q;
  logic [REL_W-1:0]  r_rel_q;
  logic              out_valid_q;
  logic              out_load;

  // RAM ports
  logic              fr_we;
  logic [IDX_W-1:0]  fr_waddr, fr_raddr;
  range_t            fr_wdata, fr_rdata;
  logic              dq_we;
  logic [DQ_W-1:0]   dq_waddr, dq_raddr;
  defer_t            dq_wdata, dq_rdata;

  // scan compare helpers
  logic [SLOT_W:0]   e_end, r_end;
  logic              e_valid, e_fit, e_better;

  bfra_ram #(.WIDTH($bits(range_t)), .DEPTH(MAX_FREE_RANGES)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  bfra_ram #(.WIDTH($bits(defer_t)), .DEPTH(DEFER_DEPTH)) u_defer_ram (
    .clk_i   (clk_i),
    .we_i    (dq_we),
    .waddr_i (dq_waddr),
    .wdata_i (dq_wdata),
    .raddr_i (dq_raddr),
    .rdata_o (dq_rdata)
  );

  // configuration port: zero-wait, write on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1:3];
  assign heap_wr = cfg_wr && (cfg_idx == REG_HEAP_SIZE);
  always_comb begin
    heap_new = pwdata[SLOT_W-1:0];
    if (heap_new == '0) begin
      heap_new = SLOT_W'(1);
    end else if (heap_new > SLOTS_MAX) begin
      heap_new = SLOTS_MAX;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HEAP_SIZE:  prdata = 64'(heap_q);
      REG_BASE_ADDR:  prdata = 64'(base_q);
      REG_HANDLE_INC: prdata = 64'(inc_q);
      default:        prdata = '0;
    endcase
  end

  assign inc_eff   = (inc_q == '0) ? INC_W'(1) : inc_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc    = in_valid_i & in_ready_o;
  assign scan_end  = (scan_q == SCAN_END);
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // one restoring divide step
  assign rem_t = {rem_q, div_q[ADR_W-1]};
  assign q_bit = (rem_t >= {1'b0, inc_eff});

  // compare unit shared by both scans
  assign e_valid  = (fr_rdata.len != '0);
  assign e_end    = {1'b0, fr_rdata.off} + {1'b0, fr_rdata.len};
  assign r_end    = {1'b0, rel_off_q} + {1'b0, rel_cnt_q};
  assign e_fit    = e_valid && (fr_rdata.len >= cnt_q);
  assign e_better = !found_q || (fr_rdata.len < best_q.len) ||
                    ((fr_rdata.len == best_q.len) && (fr_rdata.off < best_q.off));

  // range check on a popped entry, taken straight from the queue read data
  assign pre_bad = (dq_rdata.cnt == '0) || (dq_rdata.off >= heap_q) ||
                   (dq_rdata.cnt > (heap_q - dq_rdata.off));
  assign pop_ok  = (dq_rdata.frame <= frame_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (scan_q == CLR_END) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_ALLOC:   state_d = (count_i > free_q) ? S_DONE : S_A_SCAN;
            CMD_FREE:    state_d = S_F_DIV;
            CMD_RELEASE: state_d = S_R_HEAD;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_A_SCAN: if (scan_end) state_d = S_A_PICK;
      S_A_PICK: state_d = found_q ? S_A_MUL : S_DONE;
      S_A_MUL:  state_d = S_A_WR;
      S_A_WR:   state_d = S_DONE;
      S_F_DIV:  if (bit_q == BIT_W'(ADR_W - 1)) state_d = S_F_WR;
      S_F_WR:   state_d = S_DONE;
      S_R_HEAD: state_d = (fill_q == '0) ? S_DONE : S_R_CHK;
      S_R_CHK: begin
        if (!pop_ok) begin
          state_d = S_DONE;
        end else begin
          state_d = pre_bad ? S_R_HEAD : S_R_SCAN;
        end
      end
      S_R_SCAN: if (scan_end) state_d = S_R_WR1;
      S_R_WR1:  state_d = (!rel_bad_q && prev_q && next_q) ? S_R_WR2 : S_R_HEAD;
      S_R_WR2:  state_d = S_R_HEAD;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    if (heap_wr) begin
      state_d = S_CLEAR;
    end
  end

  // memory controls
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = best_idx_q;
    fr_wdata = '0;
    fr_raddr = scan_q[IDX_W-1:0];
    dq_we    = 1'b0;
    dq_waddr = tail_q;
    dq_wdata = '{frame: frame_q, off: (div_q > ADR_W'(MAX_SLOTS)) ? SLOTS_MAX
                                     : div_q[SLOT_W-1:0], cnt: cnt_q};
    dq_raddr = head_q;
    case (state_q)
      S_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = scan_q[IDX_W-1:0];
        if (scan_q == '0) begin
          fr_wdata = '{off: '0, len: heap_q};
        end
      end
      S_A_WR: begin
        fr_we    = 1'b1;
        fr_wdata = '{off: best_q.off + cnt_q, len: best_q.len - cnt_q};
      end
      S_F_WR:   dq_we = (fill_q < FILL_W'(DEFER_DEPTH));
      S_R_WR1: begin
        if (!rel_bad_q) begin
          if (prev_q) begin
            fr_we    = 1'b1;
            fr_waddr = prev_idx_q;
            fr_wdata = '{off: prev_r_q.off,
                         len: prev_r_q.len + rel_cnt_q + (next_q ? next_len_q : '0)};
          end else if (next_q) begin
            fr_we    = 1'b1;
            fr_waddr = next_idx_q;
            fr_wdata = '{off: rel_off_q, len: next_len_q + rel_cnt_q};
          end else if (hole_q) begin
            fr_we    = 1'b1;
            fr_waddr = hole_idx_q;
            fr_wdata = '{off: rel_off_q, len: rel_cnt_q};
          end
        end
      end
      S_R_WR2: begin
        // drop the upper neighbour, now folded into the lower one
        fr_we    = 1'b1;
        fr_waddr = next_idx_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      heap_q      <= SLOTS_MAX;
      base_q      <= '0;
      inc_q       <= INC_W'(32);
      scan_q      <= '0;
      prc_q       <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      free_q      <= SLOTS_MAX;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_HEAP_SIZE: begin
            heap_q <= heap_new;
            free_q <= heap_new;
            head_q <= '0;
            tail_q <= '0;
            fill_q <= '0;
          end
          REG_BASE_ADDR:  base_q <= pwdata[ADR_W-1:0];
          REG_HANDLE_INC: inc_q  <= pwdata[INC_W-1:0];
          default: ;
        endcase
      end

      // sweep counter: clearing pass and table scans; a heap write restarts it
      if (heap_wr) begin
        scan_q <= '0;
        prc_q  <= 1'b0;
      end else begin
        case (state_q)
          S_CLEAR: scan_q <= (scan_q == CLR_END) ? '0 : scan_q + 1'b1;
          S_A_SCAN, S_R_SCAN: begin
            scan_q <= scan_end ? '0 : scan_q + 1'b1;
            prc_q  <= !scan_end;
          end
          default: begin
            scan_q <= '0;
            prc_q  <= 1'b0;
          end
        endcase
      end

      case (state_q)
        S_A_WR:  free_q <= free_q - cnt_q;
        S_F_WR: begin
          if (fill_q < FILL_W'(DEFER_DEPTH)) begin
            tail_q <= (tail_q == DQ_W'(DEFER_DEPTH - 1)) ? '0 : tail_q + 1'b1;
            fill_q <= fill_q + 1'b1;
          end
        end
        S_R_CHK: begin
          if (pop_ok) begin
            head_q <= (head_q == DQ_W'(DEFER_DEPTH - 1)) ? '0 : head_q + 1'b1;
            fill_q <= fill_q - 1'b1;
          end
        end
        S_R_WR1: begin
          if (!rel_bad_q && (prev_q || next_q || hole_q)) begin
            free_q <= free_q + rel_cnt_q;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    idx_q <= scan_q[IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        cmd_q     <= command_i;
        cnt_q     <= count_i;
        frame_q   <= frame_number_i;
        div_q     <= handle_i - base_q;
        rem_q     <= '0;
        bit_q     <= '0;
        found_q   <= 1'b0;
        r_stat_q  <= (command_i == CMD_ALLOC && count_i > free_q) ? STAT_NO_FIT : STAT_OK;
        r_hdl_q   <= '0;
        r_off_q   <= '0;
        r_grant_q <= '0;
        r_rel_q   <= '0;
      end
      S_A_SCAN: begin
        if (prc_q && e_fit && e_better) begin
          found_q    <= 1'b1;
          best_q     <= fr_rdata;
          best_idx_q <= idx_q;
        end
      end
      S_A_PICK: begin
        if (!found_q) r_stat_q <= STAT_NO_FIT;
        prod_q <= best_q.off * inc_eff;
      end
      S_A_WR: begin
        r_hdl_q   <= base_q + ADR_W'(prod_q);
        r_off_q   <= best_q.off[OFF_W-1:0];
        r_grant_q <= cnt_q;
      end
      S_F_DIV: begin
        // shift one quotient bit in per cycle
        rem_q <= q_bit ? INC_W'(rem_t - {1'b0, inc_eff}) : rem_t[INC_W-1:0];
        div_q <= {div_q[ADR_W-2:0], q_bit};
        bit_q <= bit_q + 1'b1;
      end
      S_F_WR: begin
        r_off_q <= div_q[OFF_W-1:0];
        if (fill_q >= FILL_W'(DEFER_DEPTH)) r_stat_q <= STAT_QUEUE_FULL;
      end
      S_R_CHK: begin
        if (pop_ok) begin
          r_rel_q   <= r_rel_q + 1'b1;
          rel_off_q <= dq_rdata.off;
          rel_cnt_q <= dq_rdata.cnt;
          rel_bad_q <= pre_bad;
          prev_q    <= 1'b0;
          next_q    <= 1'b0;
          hole_q    <= 1'b0;
        end
      end
      S_R_SCAN: begin
        if (prc_q) begin
          if (!e_valid) begin
            if (!hole_q) begin
              hole_q     <= 1'b1;
              hole_idx_q <= idx_q;
            end
          end else begin
            if (({1'b0, fr_rdata.off} < r_end) && ({1'b0, rel_off_q} < e_end)) begin
              rel_bad_q <= 1'b1;
            end
            if (e_end == {1'b0, rel_off_q}) begin
              prev_q     <= 1'b1;
              prev_r_q   <= fr_rdata;
              prev_idx_q <= idx_q;
            end
            if ({1'b0, fr_rdata.off} == r_end) begin
              next_q     <= 1'b1;
              next_len_q <= fr_rdata.len;
              next_idx_q <= idx_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o     <= r_stat_q;
      out_handle_o <= r_hdl_q;
      out_offset_o <= r_off_q;
      granted_o    <= r_grant_q;
      free_slots_o <= free_q;
      released_o   <= (cmd_q == CMD_RELEASE) ? r_rel_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/bfra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module bfra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
